// ===== design/dssb_pkg.sv =====
// ----------------------------------------------------------------------------
// dssb_pkg
// Types and constants shared by the dual-stack shared-buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package dssb_pkg;

  localparam int DSSB_STORE_DEPTH = 1024;
  localparam int CAP_W            = 11;
  localparam int WORD_W           = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_REPLY
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic                     which_stack;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    status_t                  status;
    logic [CAP_W-1:0]         low_depth;
    logic [CAP_W-1:0]         high_depth;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic access;
    logic reply;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/dual_stack_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_core
// Two LIFO stacks in one word store, the low stack growing up from entry 0
// and the high stack growing down from the top entry in use.
// ----------------------------------------------------------------------------
// Sequence: the edge that takes start enters the access step, then the reply step,
// in which done pulses for one cycle. busy stays high for both steps, set by the
// registered read of the single-port store, so no new request is taken till reply.
// The receiver cannot stall; results hold until the next access or capacity write.
// Reset: capacity returns to 1024 and both stacks are empty; the store keeps
// its contents, and an entry is only read after it has been pushed.
`default_nettype none

module dual_stack_shared_buffer_core
  import dssb_pkg::*;
#(
  parameter int STORE_DEPTH = DSSB_STORE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  output logic                  done,
  output rsp_t                  rsp
);

  ctrl_cmd_t cmd;

  dssb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dssb_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== design/dssb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dssb_ctrl
// Sequencer: accepts a request, runs one store access, then issues the reply.
// ----------------------------------------------------------------------------
`default_nettype none

module dssb_ctrl
  import dssb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output ctrl_cmd_t      cmd,
  output logic           busy,
  output logic           done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        cmd.reply  = 1'b1;
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // An accepted word always reaches the reply step, which follows the access step.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("reply did not follow an accepted request");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("reply strobe lasted more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && cmd.access))
    else $error("access step missing after accept");

endmodule

`default_nettype wire

// ===== design/dssb_datapath.sv =====
// ----------------------------------------------------------------------------
// dssb_datapath
// Capacity register, both stack counts and the shared word store.
// ----------------------------------------------------------------------------
`default_nettype none

module dssb_datapath
  import dssb_pkg::*;
#(
  parameter int STORE_DEPTH = DSSB_STORE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_cmd_t        cmd,
  input  wire req_t             req,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  output rsp_t                  rsp
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [WORD_W-1:0] mem [STORE_DEPTH];

  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  low_count;
  logic [CAP_W-1:0]  high_count;

  op_t               op_r;
  logic              which_r;
  logic [WORD_W-1:0] val_r;
  status_t           status_r;
  logic              rd_sel;
  logic [WORD_W-1:0] rd_data;

  logic [CAP_W-1:0]  used;
  logic [CAP_W:0]    fill;
  logic              full;
  logic [CAP_W-1:0]  cnt;
  logic [CAP_W-1:0]  addr;
  logic              do_push;
  logic              do_read;

  always_comb begin
    if (32'(capacity) > 32'(STORE_DEPTH)) begin
      used = CAP_W'(STORE_DEPTH);
    end else begin
      used = capacity;
    end
    fill    = {1'b0, low_count} + {1'b0, high_count};
    full    = (fill >= {1'b0, used});
    cnt     = which_r ? high_count : low_count;
    do_push = (op_r == OP_PUSH) && !full;
    do_read = ((op_r == OP_POP) || (op_r == OP_PEEK)) && (cnt != '0);
    // The high stack grows down from the top entry in use.
    if (op_r == OP_PUSH) begin
      addr = which_r ? (used - CAP_W'(1) - high_count) : low_count;
    end else begin
      addr = which_r ? (used - high_count) : (low_count - CAP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req.op;
      which_r <= req.which_stack;
      val_r   <= req.push_value;
    end
    if (cmd.access) begin
      rd_sel <= do_read;
      case (op_r)
        OP_PUSH:          status_r <= full ? STAT_FULL : STAT_OK;
        OP_POP, OP_PEEK:  status_r <= (cnt == '0) ? STAT_EMPTY : STAT_OK;
        default:          status_r <= STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access && do_push) begin
      mem[ADDR_W'(addr)] <= val_r;
    end
    if (cmd.access && do_read) begin
      rd_data <= mem[ADDR_W'(addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      low_count  <= '0;
      high_count <= '0;
    end else if (cfg_we) begin
      // A new capacity empties both stacks.
      capacity   <= cfg_wdata;
      low_count  <= '0;
      high_count <= '0;
    end else if (cmd.access) begin
      if (do_push) begin
        if (which_r) begin
          high_count <= high_count + CAP_W'(1);
        end else begin
          low_count  <= low_count + CAP_W'(1);
        end
      end else if (do_read && (op_r == OP_POP)) begin
        if (which_r) begin
          high_count <= high_count - CAP_W'(1);
        end else begin
          low_count  <= low_count - CAP_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp.read_value = rd_sel ? $signed(rd_data) : '0;
    rsp.status     = status_r;
    rsp.low_depth  = low_count;
    rsp.high_depth = high_count;
  end

  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    fill <= {1'b0, used})
    else $error("stacks overlap in the shared store");

  a_counts_hold_in_reply: assert property (@(posedge clk) disable iff (rst)
    (cmd.reply && !cfg_we) |=> ($stable(low_count) && $stable(high_count)))
    else $error("stack counts moved outside the access step");

endmodule

`default_nettype wire
